// ===== hw/rtl/block_2d_fft_core_macros.svh =====
// Assertion macros shared by the 2D FFT core.
`ifndef BLOCK_2D_FFT_CORE_MACROS_SVH
`define BLOCK_2D_FFT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define B2FFT_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define B2FFT_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define B2FFT_ASSERT_IMP(lbl, a, b, msg)
`define B2FFT_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ===== hw/rtl/b2fft_pkg.sv =====
// Shared types, codes and the twiddle table of the 2D FFT core.
`default_nettype none
package b2fft_pkg;
    localparam int MAX_SIZE_LOG2_DEF = 6;
    localparam int IDX_W = 12;
    localparam int SMP_W = 16;
    localparam int DAT_W = 30;
    localparam int TW_W = 19;
    localparam int ROM_DEPTH = 256;
    localparam int ROM_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

    // Taylor series denominators (2n-1)*(2n) for n = 1..12
    localparam longint unsigned TAYLOR_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef logic signed [DAT_W-1:0] dat_t;
    typedef struct packed {
        dat_t re;
        dat_t im;
    } cplx_t;
    typedef logic signed [TW_W-1:0] tw_t;
    typedef logic signed [TW_W:0] twx_t;
    typedef tw_t rom_t [ROM_DEPTH];

    // Q1.17 cosine over a full turn; quarter wave from a Q30 Taylor series
    function automatic rom_t build_rom();
        rom_t rom;
        longint quarter [65];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint v;
        int q;
        int r;
        for (int k = 0; k <= 64; k++)
        begin
            x = (64'd3373259426 * longint'(k)) >> 7;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            quarter[k] = (sum + 4096) >>> 13;
        end
        for (int m = 0; m < ROM_DEPTH; m++)
        begin
            q = m / 64;
            r = m % 64;
            case (q)
                0: v = quarter[r];
                1: v = -quarter[64 - r];
                2: v = -quarter[r];
                default: v = quarter[64 - r];
            endcase
            rom[m] = TW_W'(v);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();
endpackage
`default_nettype wire

// ===== hw/rtl/b2fft_if.sv =====
// Channel interfaces of the 2D FFT core: command, result and configuration.
`default_nettype none
interface b2fft_req_if;
    logic valid;
    logic ready;
    logic [1:0] opcode;
    logic [b2fft_pkg::IDX_W-1:0] index;
    logic signed [b2fft_pkg::SMP_W-1:0] re_in;
    logic signed [b2fft_pkg::SMP_W-1:0] im_in;
    modport source (output valid, opcode, index, re_in, im_in, input ready);
    modport sink (input valid, opcode, index, re_in, im_in, output ready);
endinterface

interface b2fft_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic signed [b2fft_pkg::DAT_W-1:0] re_out;
    logic signed [b2fft_pkg::DAT_W-1:0] im_out;
    logic index_error;
    modport source (output valid, kind, re_out, im_out, index_error, input ready);
    modport sink (input valid, kind, re_out, im_out, index_error, output ready);
endinterface

interface b2fft_cfg_if;
    logic valid;
    logic ready;
    logic [b2fft_pkg::CFG_IDX_W-1:0] index;
    logic [b2fft_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/block_2d_fft_core.sv =====
// 2D FFT core top level: command decode, sample memory and transform sequencer.
// Usage:
//   req carries commands: write sample (one entry at a row-major index),
//   run transform, read element. rsp returns one result beat per command;
//   opcode three is dropped with no result. cfg writes inverse and size_log2
//   and is always ready; write it only while the core is idle.
// Sequencing:
//   write: result in the cycle after the beat; read: through S_READ, then the
//   result register. One command per cycle for writes while rsp is ready; a
//   read takes no new command until it is back in idle. run: rows then
//   columns, 2N lines of N entries. Each line runs a bit reversal walk that
//   swaps each reversed pair, then (N/2)*log2(N) butterflies (read, multiply,
//   write difference, write sum) through the single write port of the sample memory.
// Reset: inverse 0, size_log2 3. The sample memory is not cleared; an
//   entry reads as garbage until written.
// Stall: a result waits in the output register while rsp.ready is low; a new
//   command is taken only when that register is empty or being drained.
`default_nettype none
`include "block_2d_fft_core_macros.svh"
module block_2d_fft_core #(
    parameter int MAX_SIZE_LOG2 = b2fft_pkg::MAX_SIZE_LOG2_DEF
) (
    input logic        clk,
    input logic        rst_n,
    b2fft_req_if.sink  req,
    b2fft_rsp_if.source rsp,
    b2fft_cfg_if.sink  cfg
);
    import b2fft_pkg::*;

    localparam int M = MAX_SIZE_LOG2;
    localparam int AW = 2 * M;
    localparam int DEPTH = 1 << AW;
    localparam int SW = (M > 1) ? $clog2(M) : 1;
    localparam int LW = $clog2(M + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_BR_RD, S_BR_CAP, S_BR_WB,
        S_BF_RD, S_BF_MUL, S_BF_SUM, S_BF_WB
    } state_t;

    state_t state_reg;
    logic inverse_reg;
    logic [2:0] size_reg;
    logic dim_reg;
    logic [M-1:0] line_reg;
    logic [M-1:0] pos_reg;
    logic [M-1:0] bf_reg;
    logic [SW-1:0] stage_reg;
    cplx_t hold_reg;
    cplx_t sum_reg;

    logic out_valid_reg;
    logic [1:0] out_kind_reg;
    dat_t out_re_reg;
    dat_t out_im_reg;
    logic out_err_reg;
    logic out_load;

    cplx_t mem [DEPTH];
    cplx_t rdata_a;
    cplx_t rdata_b;

    logic [LW-1:0] s_eff;
    logic [M-1:0] n_m1;
    logic [M-1:0] half_m1;
    logic [M-1:0] rev_full;
    logic [M-1:0] rev_pos;
    logic [M-1:0] hmask;
    logic [M-1:0] jj;
    logic [M-1:0] k1;
    logic [M-1:0] k2;
    logic [M-1:0] pos_a;
    logic [M-1:0] pos_b;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] rd_addr_a;
    logic in_br;
    logic req_fire;
    logic idx_bad;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    cplx_t mem_wdata;
    logic [ROM_W-1:0] tw_m;
    logic [ROM_W-1:0] tw_s;
    twx_t wr;
    twx_t sn;
    twx_t wi;
    cplx_t bf_sum;
    cplx_t bf_diff;

    function automatic logic [AW-1:0] line_addr(logic d, logic [M-1:0] ln,
                                                logic [M-1:0] p, logic [LW-1:0] s);
        if (d)
            return (AW'(p) << s) | AW'(ln);
        return (AW'(ln) << s) | AW'(p);
    endfunction

    always_comb
    begin
        if (size_reg == 3'd0)
            s_eff = LW'(1);
        else if (int'(size_reg) > M)
            s_eff = LW'(M);
        else
            s_eff = LW'(size_reg);
        n_m1 = M'((1 << s_eff) - 1);
        half_m1 = M'((1 << (s_eff - 1)) - 1);
        for (int b = 0; b < M; b++)
            rev_full[b] = pos_reg[M - 1 - b];
        rev_pos = rev_full >> (M - int'(s_eff));
        hmask = M'((1 << stage_reg) - 1);
        jj = bf_reg & hmask;
        k1 = M'(((bf_reg >> stage_reg) << (stage_reg + 1)) | jj);
        k2 = k1 | M'(1 << stage_reg);
    end

    assign in_br = (state_reg == S_BR_RD) || (state_reg == S_BR_CAP)
                || (state_reg == S_BR_WB);
    assign pos_a = in_br ? pos_reg : k1;
    assign pos_b = in_br ? rev_pos : k2;
    assign addr_a = line_addr(dim_reg, line_reg, pos_a, s_eff);
    assign addr_b = line_addr(dim_reg, line_reg, pos_b, s_eff);
    assign rd_addr_a = (state_reg == S_IDLE) ? AW'(req.index) : addr_a;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire = req.valid && req.ready;
    assign idx_bad = (32'(req.index) >> (2 * int'(s_eff))) != 32'd0;
    assign cfg.ready = 1'b1;

    // twiddle: m = j * 256 / 2^(stage+1), sine a quarter turn behind
    assign tw_m = ROM_W'(32'(jj) << ((ROM_W - 1) - int'(stage_reg)));
    assign tw_s = tw_m - ROM_W'(ROM_DEPTH / 4);
    assign wr = twx_t'(COS_ROM[tw_m]);
    assign sn = twx_t'(COS_ROM[tw_s]);
    assign wi = inverse_reg ? sn : -sn;

    b2fft_bfly u_bfly (
        .clk    (clk),
        .mul_en (state_reg == S_BF_MUL),
        .wr     (wr),
        .wi     (wi),
        .xa     (rdata_a),
        .xb     (rdata_b),
        .sum    (bf_sum),
        .diff   (bf_diff)
    );

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = addr_a;
        mem_wdata = rdata_b;
        case (state_reg)
            S_IDLE:
            begin
                mem_we = req_fire && (req.opcode == OP_WRITE) && !idx_bad;
                mem_waddr = AW'(req.index);
                mem_wdata.re = DAT_W'(req.re_in);
                mem_wdata.im = DAT_W'(req.im_in);
            end
            S_BR_CAP:
            begin
                mem_we = 1'b1;
            end
            S_BR_WB:
            begin
                mem_we = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = hold_reg;
            end
            S_BF_SUM:
            begin
                mem_we = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = bf_diff;
            end
            S_BF_WB:
            begin
                mem_we = 1'b1;
                mem_wdata = sum_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // result register loads: write or bad read at the beat, read data, last butterfly
    always_comb
    begin
        case (state_reg)
            S_IDLE:
                out_load = req_fire && ((req.opcode == OP_WRITE)
                        || ((req.opcode == OP_READ) && idx_bad));
            S_READ:
                out_load = 1'b1;
            S_BF_WB:
                out_load = (bf_reg == half_m1) && (stage_reg == SW'(s_eff - LW'(1)))
                        && (line_reg == n_m1) && dim_reg;
            default:
                out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_a <= mem[rd_addr_a];
        rdata_b <= mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            size_reg <= 3'd3;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_INVERSE: inverse_reg <= cfg.data[0];
                CFG_SIZE: size_reg <= cfg.data[2:0];
                default: size_reg <= size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            dim_reg <= 1'b0;
            line_reg <= '0;
            pos_reg <= '0;
            bf_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        out_kind_reg <= req.opcode;
                        out_re_reg <= '0;
                        out_im_reg <= '0;
                        out_err_reg <= idx_bad && (req.opcode != OP_RUN);
                        case (req.opcode)
                            OP_WRITE: state_reg <= S_IDLE;
                            OP_READ:
                            begin
                                if (!idx_bad)
                                    state_reg <= S_READ;
                            end
                            OP_RUN:
                            begin
                                dim_reg <= 1'b0;
                                line_reg <= '0;
                                pos_reg <= '0;
                                state_reg <= S_BR_RD;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_READ:
                begin
                    out_kind_reg <= KIND_READ;
                    out_re_reg <= rdata_a.re;
                    out_im_reg <= rdata_a.im;
                    out_err_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_BR_RD, S_BR_WB:
                begin
                    if ((state_reg == S_BR_RD) && (pos_reg < rev_pos))
                        state_reg <= S_BR_CAP;
                    else if (pos_reg == n_m1)
                    begin
                        bf_reg <= '0;
                        stage_reg <= '0;
                        state_reg <= S_BF_RD;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + M'(1);
                        state_reg <= S_BR_RD;
                    end
                end
                S_BR_CAP:
                begin
                    hold_reg <= rdata_a;
                    state_reg <= S_BR_WB;
                end
                S_BF_RD: state_reg <= S_BF_MUL;
                S_BF_MUL: state_reg <= S_BF_SUM;
                S_BF_SUM:
                begin
                    sum_reg <= bf_sum;
                    state_reg <= S_BF_WB;
                end
                S_BF_WB:
                begin
                    if (bf_reg != half_m1)
                    begin
                        bf_reg <= bf_reg + M'(1);
                        state_reg <= S_BF_RD;
                    end
                    else if (stage_reg != SW'(s_eff - LW'(1)))
                    begin
                        bf_reg <= '0;
                        stage_reg <= stage_reg + SW'(1);
                        state_reg <= S_BF_RD;
                    end
                    else if (line_reg != n_m1)
                    begin
                        line_reg <= line_reg + M'(1);
                        pos_reg <= '0;
                        state_reg <= S_BR_RD;
                    end
                    else if (!dim_reg)
                    begin
                        dim_reg <= 1'b1;
                        line_reg <= '0;
                        pos_reg <= '0;
                        state_reg <= S_BR_RD;
                    end
                    else
                    begin
                        out_kind_reg <= KIND_DONE;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.kind = out_kind_reg;
    assign rsp.re_out = out_re_reg;
    assign rsp.im_out = out_im_reg;
    assign rsp.index_error = out_err_reg;

    `B2FFT_ASSERT_IMP(a_idle_write, (state_reg == S_IDLE) && mem_we, req_fire && (req.opcode == OP_WRITE), "memory written in idle without a write beat")
    `B2FFT_ASSERT_IMP(a_swap_order, state_reg == S_BR_WB, $past(state_reg) == S_BR_CAP, "swap write-back out of order")
    `B2FFT_ASSERT_NXT(a_write_ack, req_fire && (req.opcode == OP_WRITE), out_valid_reg && (out_kind_reg == KIND_WRITE), "write beat not acknowledged")
endmodule
`default_nettype wire

// ===== hw/rtl/b2fft_bfly.sv =====
// Radix-2 butterfly: registered complex multiply, then round and saturate.
`default_nettype none
module b2fft_bfly (
    input  logic              clk,
    input  logic              mul_en,
    input  b2fft_pkg::twx_t   wr,
    input  b2fft_pkg::twx_t   wi,
    input  b2fft_pkg::cplx_t  xa,
    input  b2fft_pkg::cplx_t  xb,
    output b2fft_pkg::cplx_t  sum,
    output b2fft_pkg::cplx_t  diff
);
    import b2fft_pkg::*;

    localparam int PW = TW_W + 1 + DAT_W;
    localparam int AW = PW + 1;
    localparam logic signed [AW-1:0] RND = AW'(65536);
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (DAT_W - 1)) - 1);
    localparam logic signed [AW-1:0] SAT_LO = -(AW'(64'sd1 <<< (DAT_W - 1)));

    logic signed [PW-1:0] p_rr_reg;
    logic signed [PW-1:0] p_ii_reg;
    logic signed [PW-1:0] p_ri_reg;
    logic signed [PW-1:0] p_ir_reg;
    logic signed [AW-1:0] tr;
    logic signed [AW-1:0] ti;

    function automatic dat_t sat30(logic signed [AW-1:0] v);
        if (v > SAT_HI)
            return DAT_W'(SAT_HI);
        else if (v < SAT_LO)
            return DAT_W'(SAT_LO);
        return DAT_W'(v);
    endfunction

    // products sized by the PW-wide targets
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            p_rr_reg <= wr * xb.re;
            p_ii_reg <= wi * xb.im;
            p_ri_reg <= wr * xb.im;
            p_ir_reg <= wi * xb.re;
        end
    end

    always_comb
    begin
        tr = (AW'(p_rr_reg) - AW'(p_ii_reg) + RND) >>> 17;
        ti = (AW'(p_ri_reg) + AW'(p_ir_reg) + RND) >>> 17;
        sum.re = sat30(AW'(xa.re) + tr);
        sum.im = sat30(AW'(xa.im) + ti);
        diff.re = sat30(AW'(xa.re) - tr);
        diff.im = sat30(AW'(xa.im) - ti);
    end
endmodule
`default_nettype wire
